### rtl/crcfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfp_pkg
// types, character codes and the crc16 byte update shared by the frame parser
// ----------------------------------------------------------------------------
package crcfp_pkg;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;

  localparam logic [7:0]  CHAR_COMMA   = 8'h2C;
  localparam logic [7:0]  CHAR_SEMI    = 8'h3B;
  localparam logic [7:0]  CHAR_ZERO    = 8'd48;
  localparam logic [7:0]  HEADER_RESET = 8'h5A;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] header_byte;
  } cfg_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [7:0]  payload_length;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/crcfp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfp_stream_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface crcfp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/crc_checked_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_parser
// ascii frame parser with crc16 ccitt-false check
// ----------------------------------------------------------------------------
// Accepts one received byte per clock unless the input stage stalls. Each byte
// is registered, then the parse step (decimal accumulate and one crc16 byte
// update) runs combinationally into the frame state and, when a frame ends or
// overruns, into the result register. The input stage only stalls when a
// result is ready while the result register still holds one that has not been
// taken. header_byte is written through cfg.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser #(
  parameter int MAX_FRAME = 128
) (
  input  logic                                           clk,
  input  logic                                           rst,
  crcfp_stream_if.sink                                   rx,
  crcfp_stream_if.sink                                   cfg,
  crcfp_stream_if.source                                 result
);

  logic [7:0] header_byte;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       res_valid;
  logic       out_free;
  logic       advance;
  logic       out_valid;
  crcfp_pkg::result_t res;
  crcfp_pkg::result_t out_data;
  crcfp_pkg::rx_item_t rx_item;
  crcfp_pkg::cfg_item_t cfg_item;

  assign rx_item  = rx.data;
  assign cfg_item = cfg.data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= crcfp_pkg::HEADER_RESET;
    end else if (cfg.valid) begin
      header_byte <= cfg_item.header_byte;
    end
  end

  assign out_free = !out_valid || result.ready;
  assign advance  = s1_valid && (!res_valid || out_free);
  assign rx.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx_item.rx_byte;
    end
  end

  crcfp_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .header_byte (header_byte),
    .item_valid  (s1_valid),
    .item_byte   (s1_byte),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_rx_lands: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready |=> s1_valid)
    else $error("accepted byte not held in input stage");

  a_overrun_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == crcfp_pkg::ST_OVERRUN |->
      out_data.computed_crc == 16'h0000 && out_data.received_crc == 16'h0000
      && out_data.payload_length == 8'h00)
    else $error("overrun result carries nonzero fields");

  a_match_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == crcfp_pkg::ST_MATCH |->
      out_data.computed_crc == out_data.received_crc)
    else $error("match status with differing crcs");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule

### rtl/crcfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfp_parser
// frame state and the per-byte parse step: header hunt, decimal length,
// payload crc, decimal received crc, result and overrun detection
// ----------------------------------------------------------------------------
module crcfp_parser #(
  parameter int MAX_FRAME = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          header_byte,
  input  logic                item_valid,
  input  logic [7:0]          item_byte,
  input  logic                advance,
  output logic                res_valid,
  output crcfp_pkg::result_t  res
);

  localparam logic [7:0]  MaxFrame8  = 8'(MAX_FRAME);
  localparam logic [11:0] MaxFrame12 = 12'(MAX_FRAME);

  crcfp_pkg::phase_t phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [15:0] received_crc_acc, received_crc_acc_next;
  logic [7:0]  payload_count, payload_count_next;

  logic [7:0]  digit;
  logic [11:0] len_value;
  logic        emit;
  crcfp_pkg::result_t res_next;

  assign digit     = item_byte - crcfp_pkg::CHAR_ZERO;
  assign len_value = ({4'b0, frame_length} << 3) + ({4'b0, frame_length} << 1) + {4'b0, digit};

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    frame_length_next     = frame_length;
    crc_accumulator_next  = crc_accumulator;
    received_crc_acc_next = received_crc_acc;
    payload_count_next    = payload_count;
    emit                  = 1'b0;
    res_next              = '0;
    res_next.status       = crcfp_pkg::ST_OVERRUN;

    if (phase == crcfp_pkg::PH_HUNT) begin
      if (item_byte == header_byte) begin
        phase_next      = crcfp_pkg::PH_LEN;
        byte_count_next = 8'd1;
      end
    end else if (byte_count >= MaxFrame8) begin
      emit = 1'b1;
    end else begin
      unique case (phase)
        crcfp_pkg::PH_LEN: begin
          if (item_byte == crcfp_pkg::CHAR_COMMA) begin
            phase_next = crcfp_pkg::PH_PAY;
          end else if (len_value > MaxFrame12) begin
            emit = 1'b1;
          end else begin
            frame_length_next = len_value[7:0];
          end
        end
        crcfp_pkg::PH_PAY: begin
          if (item_byte == crcfp_pkg::CHAR_SEMI) begin
            phase_next = crcfp_pkg::PH_CRC;
          end else begin
            crc_accumulator_next = crcfp_pkg::crc16_byte(crc_accumulator, item_byte);
            payload_count_next   = payload_count + 8'd1;
          end
        end
        crcfp_pkg::PH_CRC: begin
          received_crc_acc_next = (received_crc_acc << 3) + (received_crc_acc << 1)
                                  + {8'h00, item_byte} - {8'h00, crcfp_pkg::CHAR_ZERO};
        end
        default: begin
          phase_next = crcfp_pkg::PH_HUNT;
        end
      endcase
      if (!emit) begin
        byte_count_next = byte_count + 8'd1;
        if ((phase_next == crcfp_pkg::PH_PAY || phase_next == crcfp_pkg::PH_CRC)
            && byte_count_next == frame_length_next) begin
          emit                    = 1'b1;
          res_next.status         = (crc_accumulator_next == received_crc_acc_next)
                                    ? crcfp_pkg::ST_MATCH : crcfp_pkg::ST_MISMATCH;
          res_next.computed_crc   = crc_accumulator_next;
          res_next.received_crc   = received_crc_acc_next;
          res_next.payload_length = payload_count_next;
        end
      end
    end

    if (emit) begin
      phase_next            = crcfp_pkg::PH_HUNT;
      byte_count_next       = '0;
      frame_length_next     = '0;
      crc_accumulator_next  = crcfp_pkg::CRC_INIT;
      received_crc_acc_next = '0;
      payload_count_next    = '0;
    end
  end

  assign res_valid = item_valid && emit;
  assign res       = res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= crcfp_pkg::PH_HUNT;
      byte_count       <= '0;
      frame_length     <= '0;
      crc_accumulator  <= crcfp_pkg::CRC_INIT;
      received_crc_acc <= '0;
      payload_count    <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      frame_length     <= frame_length_next;
      crc_accumulator  <= crc_accumulator_next;
      received_crc_acc <= received_crc_acc_next;
      payload_count    <= payload_count_next;
    end
  end

endmodule
